// ===== sv/abrci_pkg.sv =====
// Shared types, constants and helper functions for the banked register file.
`default_nettype none
package abrci_pkg;

    typedef enum logic [2:0] {
        OP_READ_REG   = 3'd0,
        OP_WRITE_REG  = 3'd1,
        OP_READ_CPSR  = 3'd2,
        OP_WRITE_CPSR = 3'd3,
        OP_READ_SPSR  = 3'd4,
        OP_WRITE_SPSR = 3'd5,
        OP_COND_TEST  = 3'd6,
        OP_IRQ_POLL   = 3'd7
    } op_t;

    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    // SPSR slot numbers; SLOT_NONE for USR, SYS and undefined modes
    localparam logic [2:0] SLOT_FIQ  = 3'd0;
    localparam logic [2:0] SLOT_SVC  = 3'd1;
    localparam logic [2:0] SLOT_ABT  = 3'd2;
    localparam logic [2:0] SLOT_IRQ  = 3'd3;
    localparam logic [2:0] SLOT_UND  = 3'd4;
    localparam logic [2:0] SLOT_NONE = 3'd5;

    localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;
    localparam logic [31:0] IRQ_VECTOR = 32'h0000_0018;
    localparam logic [31:0] LR_OFFSET  = 32'd4;

    localparam int unsigned IN_TDATA_W  = 80;
    localparam int unsigned OUT_TDATA_W = 40;

    typedef struct packed {
        logic load;     // capture the input transfer
        logic execute;  // run the captured operation, load result register
    } cmd_t;

    function automatic logic [2:0] bank_slot(input logic [4:0] mode);
        logic [2:0] s;
        unique case (mode)
            MODE_FIQ: s = SLOT_FIQ;
            MODE_SVC: s = SLOT_SVC;
            MODE_ABT: s = SLOT_ABT;
            MODE_IRQ: s = SLOT_IRQ;
            MODE_UND: s = SLOT_UND;
            default:  s = SLOT_NONE;
        endcase
        return s;
    endfunction

    function automatic logic mode_valid(input logic [4:0] mode);
        return (mode == MODE_USR) || (mode == MODE_SYS) || (bank_slot(mode) != SLOT_NONE);
    endfunction

    function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] nzcv);
        logic n;
        logic z;
        logic c;
        logic v;
        logic r;
        n = nzcv[3];
        z = nzcv[2];
        c = nzcv[1];
        v = nzcv[0];
        unique case (cc)
            4'h0: r = z;
            4'h1: r = !z;
            4'h2: r = c;
            4'h3: r = !c;
            4'h4: r = n;
            4'h5: r = !n;
            4'h6: r = v;
            4'h7: r = !v;
            4'h8: r = c && !z;
            4'h9: r = !c || z;
            4'hA: r = (n == v);
            4'hB: r = (n != v);
            4'hC: r = !z && (n == v);
            4'hD: r = z || (n != v);
            4'hE: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/abrci_ctrl.sv =====
// Controller: sequences capture, execute and result handoff.
`default_nettype none
module abrci_ctrl
    import abrci_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output cmd_t      cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   exec_go;

    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        // result register free, or its transfer completes this cycle
        exec_go     = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);
        cmd.load    = s_tvalid && (state_reg == ST_IDLE);
        cmd.execute = exec_go;
        m_tvalid    = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (exec_go)
                        state_reg <= ST_IDLE;
                end
            endcase
            if (exec_go)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== sv/abrci_dp.sv =====
// Datapath: banked register file, CPSR/SPSR, condition check, IRQ entry.
`default_nettype none
module abrci_dp
    import abrci_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    input  wire logic [IN_TDATA_W-1:0]  in_tdata,
    input  wire logic [2:0]             in_tuser,
    output logic      [OUT_TDATA_W-1:0] out_tdata
);

    // captured item
    op_t         op_reg;
    logic [3:0]  idx_reg;
    logic [31:0] wd_reg;
    logic [3:0]  cc_reg;
    logic [15:0] ie_reg;
    logic [15:0] if_reg;
    logic        ime_reg;

    // architectural state
    logic [31:0] base_regs [16];
    logic [31:0] fiq_bank  [7];
    logic [31:0] sp_lr     [8];
    logic [31:0] spsr_regs [5];
    logic [31:0] cpsr_reg;

    // result register
    logic [31:0] rd_reg;
    logic        pass_reg;
    logic        pend_reg;
    logic        taken_reg;
    logic        bad_reg;

    logic [31:0] rd_next;
    logic        pass_next;
    logic        pend_next;
    logic        taken_next;
    logic        bad_next;

    logic [2:0]  slot;
    logic        in_fiq_bank;
    logic        in_sp_lr;
    logic [2:0]  sp_lr_idx;
    logic [31:0] reg_rdata;
    logic [31:0] spsr_rdata;
    logic        pend;
    logic        take;
    logic        wd_mode_ok;

    always_comb
    begin
        slot        = bank_slot(cpsr_reg[4:0]);
        in_fiq_bank = (slot == SLOT_FIQ) && (idx_reg >= 4'd8) && (idx_reg != 4'd15);
        in_sp_lr    = (slot != SLOT_FIQ) && (slot != SLOT_NONE)
                      && ((idx_reg == 4'd13) || (idx_reg == 4'd14));
        // slot SVC..UND maps to pairs 0..3, r13 first
        sp_lr_idx   = {slot[1:0] - 2'd1, ~idx_reg[0]};
        if (in_fiq_bank)
            reg_rdata = fiq_bank[idx_reg[2:0]];
        else if (in_sp_lr)
            reg_rdata = sp_lr[sp_lr_idx];
        else
            reg_rdata = base_regs[idx_reg];
        spsr_rdata  = (slot == SLOT_NONE) ? cpsr_reg : spsr_regs[slot];
        pend        = |(ie_reg & if_reg);
        take        = pend && ime_reg && !cpsr_reg[7];
        wd_mode_ok  = mode_valid(wd_reg[4:0]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(in_tuser);
            idx_reg <= in_tdata[3:0];
            wd_reg  <= in_tdata[35:4];
            cc_reg  <= in_tdata[39:36];
            ie_reg  <= in_tdata[55:40];
            if_reg  <= in_tdata[71:56];
            ime_reg <= in_tdata[72];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                base_regs[i] <= '0;
            for (int i = 0; i < 7; i++)
                fiq_bank[i] <= '0;
            for (int i = 0; i < 8; i++)
                sp_lr[i] <= '0;
            for (int i = 0; i < 5; i++)
                spsr_regs[i] <= '0;
            cpsr_reg <= CPSR_RESET;
        end
        else if (cmd.execute)
        begin
            unique case (op_reg)
                OP_WRITE_REG:
                begin
                    if (in_fiq_bank)
                        fiq_bank[idx_reg[2:0]] <= wd_reg;
                    else if (in_sp_lr)
                        sp_lr[sp_lr_idx] <= wd_reg;
                    else
                        base_regs[idx_reg] <= wd_reg;
                end
                OP_WRITE_CPSR:
                    cpsr_reg <= wd_reg;
                OP_WRITE_SPSR:
                begin
                    if (slot == SLOT_NONE)
                        cpsr_reg <= wd_reg;
                    else
                        spsr_regs[slot] <= wd_reg;
                end
                OP_IRQ_POLL:
                begin
                    if (take)
                    begin
                        spsr_regs[SLOT_IRQ] <= cpsr_reg;
                        cpsr_reg <= {cpsr_reg[31:8], 1'b1, cpsr_reg[6], 1'b0, MODE_IRQ};
                        sp_lr[5] <= base_regs[15] + LR_OFFSET;   // LR_irq
                        base_regs[15] <= IRQ_VECTOR;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result fields; everything not produced by the operation reads as zero
    always_comb
    begin
        rd_next    = '0;
        pass_next  = 1'b0;
        pend_next  = 1'b0;
        taken_next = 1'b0;
        bad_next   = 1'b0;
        unique case (op_reg)
            OP_READ_REG:   rd_next = reg_rdata;
            OP_READ_CPSR:  rd_next = cpsr_reg;
            OP_READ_SPSR:  rd_next = spsr_rdata;
            OP_WRITE_CPSR: bad_next = !wd_mode_ok;
            OP_WRITE_SPSR: bad_next = (slot == SLOT_NONE) && !wd_mode_ok;
            OP_COND_TEST:  pass_next = cond_holds(cc_reg, cpsr_reg[31:28]);
            OP_IRQ_POLL:
            begin
                pend_next  = pend;
                taken_next = take;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rd_reg    <= rd_next;
            pass_reg  <= pass_next;
            pend_reg  <= pend_next;
            taken_reg <= taken_next;
            bad_reg   <= bad_next;
        end
    end

    assign out_tdata = {4'b0, bad_reg, taken_reg, pend_reg, pass_reg, rd_reg};

endmodule
`default_nettype wire

// ===== sv/arm_banked_regs_cond_irq_entry.sv =====
// Top level: ARMv4T-style banked register file with condition check and IRQ entry.
// A transfer accepted in ST_IDLE is captured, then executes in ST_EXEC once the result
// register is free or its transfer completes; the result is valid right after execution.
// One item in flight: the controller accepts a new item only after the previous one has executed.
// The input side reopens as soon as the item executes; the result register decouples the sides.
// Reset (rst_n low, async): all registers and SPSRs zero, CPSR = 0xD3 (SVC, I and F set).
`default_nettype none
module arm_banked_regs_cond_irq_entry
    import abrci_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // reg_index[3:0], write_data[35:4], cond_code[39:36], irq_enable_mask[55:40],
    // irq_request_flags[71:56], irq_master_enable[72], zero fill [79:73]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  wire logic [2:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // read_data[31:0], cond_pass[32], irq_pending[33], irq_taken[34], bad_mode[35],
    // zero fill [39:36]
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    cmd_t cmd;

    // controller: one item in flight, result handed off through m_tvalid
    abrci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath: holds all architectural state and the result payload
    abrci_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_tdata  (s_tdata),
        .in_tuser  (s_tuser),
        .out_tdata (m_tdata)
    );

endmodule
`default_nettype wire
